### rtl/deq_pkg.sv
// Shared definitions for the double-ended queue: action and status codes,
// controller states and the default depth. No dependencies.
package deq_pkg;

   localparam int unsigned DEQ_DEPTH_DEFAULT = 32;
   localparam int unsigned DEQ_VALUE_WIDTH   = 32;
   localparam int unsigned DEQ_ACTION_WIDTH  = 3;
   localparam int unsigned DEQ_STATUS_WIDTH  = 2;

   typedef enum logic [DEQ_ACTION_WIDTH-1:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_DUMP_FWD   = 3'd4,
      ACT_DUMP_REV   = 3'd5
   } action_type;

   typedef enum logic [DEQ_STATUS_WIDTH-1:0] {
      STAT_OK        = 2'd0,
      STAT_OVERFLOW  = 2'd1,
      STAT_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_DUMP
   } state_type;

endpackage

### rtl/deq_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// The read data holds while the read enable is low. No dependencies.
module deq_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/double_ended_queue.sv
// Double-ended queue of signed 32-bit values held in a ring store in one RAM.
// A push, overflow or underflow result is offered in the cycle after the request
// transfer; a pop result and a dump's first entry pass through the RAM read register and
// then the output register. Pushes are taken one per cycle while responses are accepted;
// a pop or dump takes no new request until its last result is loaded into the output register.
// Reset (synchronous) empties the queue; RAM contents stay undefined, with no clear pass.
module double_ended_queue #(
   parameter int unsigned DEPTH = deq_pkg::DEQ_DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request channel.
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [deq_pkg::DEQ_VALUE_WIDTH-1:0]    req_tdata,  // [31:0] push_value
   input  logic [deq_pkg::DEQ_ACTION_WIDTH-1:0]   req_tuser,  // [2:0] action
   // Response channel.
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [deq_pkg::DEQ_VALUE_WIDTH-1:0]    rsp_tdata,  // [31:0] out_value
   output logic [deq_pkg::DEQ_STATUS_WIDTH-1:0]   rsp_tuser,  // [1:0] status
   output logic                                   rsp_tlast
);

   import deq_pkg::*;

   // Slot addresses need AW bits; the count holds 0..DEPTH; SW is wide enough for
   // sums of a slot and an offset and for comparisons against the count.
   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned SW = AW + 1;
   localparam int unsigned VW = DEQ_VALUE_WIDTH;

   // Ring position of a logical offset from the front, wrapped once.
   function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(off);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   state_type         state_ff, state_in;
   logic [AW-1:0]     front_ff, front_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     idx_ff, idx_in;        // index of the dump entry now in the RAM read register
   logic              rev_ff, rev_in;        // dump runs back to front
   logic              rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]     rsp_value_ff, rsp_value_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [VW-1:0]     ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [VW-1:0]     ram_rd_data;

   logic              out_free;
   logic              req_fire;
   action_type        action;
   logic              q_full;
   logic              q_empty;
   logic              q_is_push;
   logic              q_is_pop;
   logic              q_is_dump;
   logic [AW-1:0]     count_m1;
   logic [AW-1:0]     idx_next;
   logic              dump_last;

   // The output register can take a new result when it is empty or being drained.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign action     = action_type'(req_tuser);

   assign q_full   = (SW'(count_ff) >= SW'(DEPTH));
   assign q_empty  = (count_ff == '0);
   assign count_m1 = AW'(SW'(count_ff) - SW'(1));
   assign idx_next = AW'(SW'(idx_ff) + SW'(1));
   assign dump_last = ((SW'(idx_ff) + SW'(1)) == SW'(count_ff));

   always_comb begin
      q_is_push = 1'b0;
      q_is_pop  = 1'b0;
      q_is_dump = 1'b0;
      unique case (action) inside
         ACT_PUSH_FRONT, ACT_PUSH_BACK: q_is_push = 1'b1;
         ACT_POP_FRONT, ACT_POP_BACK:   q_is_pop  = 1'b1;
         ACT_DUMP_FWD, ACT_DUMP_REV:    q_is_dump = 1'b1;
         default: ;
      endcase
   end

   // Next-state logic. A pop or dump on a non-empty queue waits for its RAM read.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && !q_empty && q_is_pop) begin
               state_in = ST_POP;
            end else if (req_fire && !q_empty && q_is_dump) begin
               state_in = ST_DUMP;
            end
         end
         ST_POP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DUMP: begin
            if (out_free && dump_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and RAM control. Front and count are updated at the request transfer,
   // so the RAM read issued in the same cycle uses the state from before the update.
   always_comb begin
      front_in      = front_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      rev_in        = rev_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = front_ff;
      ram_wr_data   = req_tdata;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = front_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (q_is_push) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = '0;
                  rsp_last_in  = 1'b1;
                  if (q_full) begin
                     rsp_status_in = STAT_OVERFLOW;
                  end else begin
                     rsp_status_in = STAT_OK;
                     ram_wr_en     = 1'b1;
                     count_in      = CW'(SW'(count_ff) + SW'(1));
                     if (action == ACT_PUSH_FRONT) begin
                        front_in    = (front_ff == '0) ? AW'(DEPTH - 1)
                                                       : AW'(SW'(front_ff) - SW'(1));
                        ram_wr_addr = front_in;
                     end else begin
                        ram_wr_addr = slot_at(front_ff, AW'(count_ff));
                     end
                  end
               end else if (q_is_pop || q_is_dump) begin
                  if (q_empty) begin
                     // Empty pop or empty dump: a single underflow result.
                     rsp_valid_in  = 1'b1;
                     rsp_value_in  = '0;
                     rsp_status_in = STAT_UNDERFLOW;
                     rsp_last_in   = 1'b1;
                  end else if (q_is_pop) begin
                     ram_rd_en = 1'b1;
                     count_in  = CW'(SW'(count_ff) - SW'(1));
                     if (action == ACT_POP_FRONT) begin
                        ram_rd_addr = front_ff;
                        front_in    = slot_at(front_ff, AW'(1));
                     end else begin
                        ram_rd_addr = slot_at(front_ff, count_m1);
                     end
                  end else begin
                     ram_rd_en   = 1'b1;
                     idx_in      = '0;
                     rev_in      = (action == ACT_DUMP_REV);
                     ram_rd_addr = (action == ACT_DUMP_REV) ? slot_at(front_ff, count_m1)
                                                            : front_ff;
                  end
               end
            end
         end
         ST_POP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = ram_rd_data;
               rsp_status_in = STAT_OK;
               rsp_last_in   = 1'b1;
            end
         end
         ST_DUMP: begin
            // Hand over the entry in the read register and, unless it is the last, fetch the following one.
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = ram_rd_data;
               rsp_status_in = STAT_OK;
               rsp_last_in   = dump_last;
               if (!dump_last) begin
                  ram_rd_en   = 1'b1;
                  idx_in      = idx_next;
                  ram_rd_addr = rev_ff ? slot_at(front_ff, AW'(SW'(count_m1) - SW'(idx_next)))
                                       : slot_at(front_ff, idx_next);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      rev_ff        <= rev_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   deq_ram #(
      .WIDTH (VW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
